FILE: hw/rtl/slc8d_pkg.sv
// Shared constants, types and the CRC8 bit step for the sync/length/type/CRC8 deframer.
package slc8d_pkg;

  // Store and queue depths
  localparam int RX_DEPTH  = 512;
  localparam int OUT_DEPTH = 512;

  // Store address, store count, and scan index widths (index covers i + LEN + 4)
  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int RX_CW = $clog2(RX_DEPTH + 1);
  localparam int IW    = $clog2(RX_DEPTH + 264);
  localparam int QAW   = $clog2(OUT_DEPTH);
  localparam int QCW   = $clog2(OUT_DEPTH + 1);

  // Configuration port
  localparam int CFG_AW = 2;
  localparam logic [CFG_AW-1:0] REG_SYNC_BYTE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_CRC_POLY  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CRC_INIT  = 2'd2;

  localparam logic [7:0] SYNC_RESET = 8'hA5;
  localparam logic [7:0] POLY_RESET = 8'h07;
  localparam logic [7:0] INIT_RESET = 8'h00;

  // Input beat kinds
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // One output queue entry
  typedef struct packed {
    logic       empty_payload;
    logic       last_of_frame;
    logic       first_of_frame;
    logic [7:0] frame_type;
    logic [7:0] payload_byte;
  } q_entry_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POP,
    ST_FIND,
    ST_FIND_CHK,
    ST_HDR,
    ST_LEN,
    ST_TYPE,
    ST_SHIFT,
    ST_FEED,
    ST_CMP,
    ST_ENQ,
    ST_CUT
  } state_t;

  // One MSB-first CRC8 shift step
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] poly);
    logic [7:0] sh;
    sh = {crc[6:0], 1'b0};
    return crc[7] ? (sh ^ poly) : sh;
  endfunction

endpackage

FILE: hw/rtl/sync_len_type_crc8_deframer_top.sv
// Top level of the sync/length/type/CRC8 deframer: byte store, scan sequencer, output queue.
//
// Input channel s_*: each beat is a push (s_tuser = 0) of the received byte in s_tdata,
// or a pop (s_tuser = 1). A push causes no output beat. A pop causes exactly one output
// beat on m_*, holding the next queued payload entry or, if the queue is empty, an
// entry with out_valid low and zero fields; both sticky overflow flags ride along.
// Pushed bytes collect in a circular byte store; after each push a sequencer rescans
// it from the front: find the sync byte, read LEN and TYPE, and run the CRC8 through
// a single bit-serial CRC unit, one shift per cycle, reading the store one byte at a
// time through its registered read port. Good frames are copied byte by byte into
// the output queue and cut from the store; a good frame with no room in the queue is
// cut uncopied and sets out_overflow. A pop of a queued entry passes through the queue
// read, then the output register; an empty pop loads the output register directly.
// A push keeps the sequencer busy for a sync search over the stored bytes plus a CRC
// check of each complete candidate. s_tready is low while the sequencer works and
// while an undelivered output beat would be overwritten.
// Reset (rst, synchronous) empties store and queue, clears the flags and loads the
// register defaults (sync 0xA5, poly 0x07, init 0x00). No clearing pass is needed.
// A stalled receiver (m_tready low) holds the output beat; further pops and pushes
// wait until it is taken. Write configuration via cfg_we only while the block is idle.
module sync_len_type_crc8_deframer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
  input  logic                             s_tuser,   // [0] cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,   // [7:0] frame_type, [15:8] payload_byte,
                                                      // [16] rx_overflow, [17] out_overflow
  output logic [2:0]                       m_tuser,   // [0] out_valid, [1] first_of_frame,
                                                      // [2] empty_payload
  output logic                             m_tlast,   // last_of_frame
  input  logic                             cfg_we,
  input  logic [slc8d_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [7:0]                       cfg_wdata
);

  localparam logic [slc8d_pkg::IW:0]  RX_DEPTH_W  = (slc8d_pkg::IW+1)'(slc8d_pkg::RX_DEPTH);
  localparam logic [slc8d_pkg::QCW:0] OUT_DEPTH_W = (slc8d_pkg::QCW+1)'(slc8d_pkg::OUT_DEPTH);

  // Memories
  logic [7:0]                rx_mem [slc8d_pkg::RX_DEPTH];
  slc8d_pkg::q_entry_t       q_mem  [slc8d_pkg::OUT_DEPTH];

  // Registers
  slc8d_pkg::state_t         state, state_next;
  logic [7:0]                sync_byte, crc_poly, crc_init;
  logic [slc8d_pkg::RX_AW-1:0] rx_head, rx_head_next;
  logic [slc8d_pkg::RX_CW-1:0] rx_fill, rx_fill_next;
  logic [slc8d_pkg::QAW-1:0] out_head, out_head_next;
  logic [slc8d_pkg::QCW-1:0] out_fill, out_fill_next;
  logic                      rx_ovf, rx_ovf_next, out_ovf, out_ovf_next;
  logic [slc8d_pkg::IW-1:0]  idx, idx_next;
  logic [7:0]                len_r, len_next, type_r, type_next, crc, crc_next;
  logic [8:0]                k, k_next;
  logic [2:0]                bitc, bitc_next;
  logic                      m_valid_next;
  logic [23:0]               m_data_next;
  logic [2:0]                m_user_next;
  logic                      m_last_next;
  logic [7:0]                rx_rd;
  slc8d_pkg::q_entry_t       q_rd;

  // Memory control
  logic                      rx_we, q_we;
  logic [slc8d_pkg::RX_AW-1:0] rx_waddr, rx_raddr;
  logic [slc8d_pkg::IW-1:0]  rd_idx;
  logic [slc8d_pkg::IW:0]    rd_sum, wr_sum;
  logic [slc8d_pkg::QAW:0]   q_sum;
  logic [slc8d_pkg::QAW-1:0] q_waddr;
  slc8d_pkg::q_entry_t       q_wdata;
  logic [slc8d_pkg::IW-1:0]  fill_w, frame_end;
  logic [8:0]                count;
  logic [slc8d_pkg::QCW:0]   q_need;
  logic [slc8d_pkg::IW:0]    cut_sum;

  // Store address from logical index: head plus index, wrapped once
  always_comb begin
    rd_sum   = {1'b0, (slc8d_pkg::IW)'(rx_head)} + {1'b0, rd_idx};
    rx_raddr = (rd_sum >= RX_DEPTH_W) ? slc8d_pkg::RX_AW'(rd_sum - RX_DEPTH_W)
                                      : slc8d_pkg::RX_AW'(rd_sum);
    q_sum    = {1'b0, out_head} + (slc8d_pkg::QAW+1)'(out_fill);
    q_waddr  = (q_sum >= (slc8d_pkg::QAW+1)'(slc8d_pkg::OUT_DEPTH))
               ? slc8d_pkg::QAW'(q_sum - (slc8d_pkg::QAW+1)'(slc8d_pkg::OUT_DEPTH))
               : slc8d_pkg::QAW'(q_sum);
  end

  assign fill_w    = (slc8d_pkg::IW)'(rx_fill);
  assign frame_end = idx + (slc8d_pkg::IW)'(len_r) + (slc8d_pkg::IW)'(4);
  assign count     = (len_r == 8'd0) ? 9'd1 : {1'b0, len_r};
  assign q_need    = {1'b0, out_fill} + (slc8d_pkg::QCW+1)'(count);
  assign s_tready  = (state == slc8d_pkg::ST_IDLE) && (!m_tvalid || m_tready);

  // Sequencer: next state and datapath
  always_comb begin
    state_next    = state;
    rx_head_next  = rx_head;
    rx_fill_next  = rx_fill;
    out_head_next = out_head;
    out_fill_next = out_fill;
    rx_ovf_next   = rx_ovf;
    out_ovf_next  = out_ovf;
    idx_next      = idx;
    len_next      = len_r;
    type_next     = type_r;
    crc_next      = crc;
    k_next        = k;
    bitc_next     = bitc;
    m_valid_next  = m_tvalid && !m_tready;
    m_data_next   = m_tdata;
    m_user_next   = m_tuser;
    m_last_next   = m_tlast;
    rd_idx        = idx;
    rx_we         = 1'b0;
    rx_waddr      = '0;
    wr_sum        = '0;
    q_we          = 1'b0;
    q_wdata       = '0;
    cut_sum       = '0;
    case (state)
      slc8d_pkg::ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          if (s_tuser == slc8d_pkg::CMD_PUSH) begin
            // Drop the oldest byte when full, then append
            if (rx_fill == slc8d_pkg::RX_CW'(slc8d_pkg::RX_DEPTH)) begin
              rx_head_next = (rx_head == slc8d_pkg::RX_AW'(slc8d_pkg::RX_DEPTH - 1))
                             ? '0 : rx_head + 1'b1;
              rx_ovf_next  = 1'b1;
              rx_waddr     = rx_head;
            end else begin
              rx_fill_next = rx_fill + 1'b1;
              wr_sum       = {1'b0, (slc8d_pkg::IW)'(rx_head)} + {1'b0, fill_w};
              rx_waddr     = (wr_sum >= RX_DEPTH_W) ? slc8d_pkg::RX_AW'(wr_sum - RX_DEPTH_W)
                                                    : slc8d_pkg::RX_AW'(wr_sum);
            end
            rx_we      = 1'b1;
            idx_next   = '0;
            state_next = slc8d_pkg::ST_FIND;
          end else if (out_fill == '0) begin
            // Empty pop: zero entry with flags
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, out_ovf, rx_ovf, 16'd0};
            m_user_next  = 3'd0;
            m_last_next  = 1'b0;
          end else begin
            state_next = slc8d_pkg::ST_POP;
          end
        end
      end
      slc8d_pkg::ST_POP: begin
        m_valid_next  = 1'b1;
        m_data_next   = {6'd0, out_ovf, rx_ovf, q_rd.payload_byte, q_rd.frame_type};
        m_user_next   = {q_rd.empty_payload, q_rd.first_of_frame, 1'b1};
        m_last_next   = q_rd.last_of_frame;
        out_head_next = (out_head == slc8d_pkg::QAW'(slc8d_pkg::OUT_DEPTH - 1))
                        ? '0 : out_head + 1'b1;
        out_fill_next = out_fill - 1'b1;
        state_next    = slc8d_pkg::ST_IDLE;
      end
      slc8d_pkg::ST_FIND: begin
        // Scan for the sync byte; none left drops the whole store
        if (idx >= fill_w) begin
          rx_fill_next = '0;
          state_next   = slc8d_pkg::ST_IDLE;
        end else begin
          state_next = slc8d_pkg::ST_FIND_CHK;
        end
      end
      slc8d_pkg::ST_FIND_CHK: begin
        if (rx_rd == sync_byte) begin
          state_next = slc8d_pkg::ST_HDR;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = slc8d_pkg::ST_FIND;
        end
      end
      slc8d_pkg::ST_HDR: begin
        rd_idx = idx + 1'b1;
        if (idx + (slc8d_pkg::IW)'(3) >= fill_w) begin
          state_next = slc8d_pkg::ST_IDLE;
        end else begin
          state_next = slc8d_pkg::ST_LEN;
        end
      end
      slc8d_pkg::ST_LEN: begin
        // Stop when the candidate is not complete yet
        len_next = rx_rd;
        rd_idx   = idx + (slc8d_pkg::IW)'(2);
        if (idx + (slc8d_pkg::IW)'(rx_rd) + (slc8d_pkg::IW)'(4) > fill_w) begin
          state_next = slc8d_pkg::ST_IDLE;
        end else begin
          state_next = slc8d_pkg::ST_TYPE;
        end
      end
      slc8d_pkg::ST_TYPE: begin
        type_next  = rx_rd;
        crc_next   = crc_init ^ len_r;
        k_next     = '0;
        bitc_next  = '0;
        state_next = slc8d_pkg::ST_SHIFT;
      end
      slc8d_pkg::ST_SHIFT: begin
        // One CRC bit per cycle
        crc_next  = slc8d_pkg::crc_step(crc, crc_poly);
        bitc_next = bitc + 1'b1;
        if (bitc == 3'd7) begin
          if (k == {1'b0, len_r} + 9'd1) begin
            rd_idx     = idx + (slc8d_pkg::IW)'(3) + (slc8d_pkg::IW)'(len_r);
            state_next = slc8d_pkg::ST_CMP;
          end else begin
            k_next     = k + 1'b1;
            rd_idx     = idx + (slc8d_pkg::IW)'(2) + (slc8d_pkg::IW)'(k);
            state_next = slc8d_pkg::ST_FEED;
          end
        end
      end
      slc8d_pkg::ST_FEED: begin
        crc_next   = crc ^ ((k == 9'd1) ? type_r : rx_rd);
        bitc_next  = '0;
        state_next = slc8d_pkg::ST_SHIFT;
      end
      slc8d_pkg::ST_CMP: begin
        rd_idx = idx + (slc8d_pkg::IW)'(3);
        k_next = '0;
        if (rx_rd == crc) begin
          if (q_need > OUT_DEPTH_W) begin
            out_ovf_next = 1'b1;
            state_next   = slc8d_pkg::ST_CUT;
          end else begin
            state_next = slc8d_pkg::ST_ENQ;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = slc8d_pkg::ST_FIND;
        end
      end
      slc8d_pkg::ST_ENQ: begin
        // Copy one payload byte per cycle into the queue
        q_we                   = 1'b1;
        q_wdata.payload_byte   = (len_r == 8'd0) ? 8'd0 : rx_rd;
        q_wdata.frame_type     = type_r;
        q_wdata.first_of_frame = (k == '0);
        q_wdata.last_of_frame  = (k == count - 9'd1);
        q_wdata.empty_payload  = (len_r == 8'd0);
        out_fill_next          = out_fill + 1'b1;
        k_next                 = k + 1'b1;
        rd_idx                 = idx + (slc8d_pkg::IW)'(4) + (slc8d_pkg::IW)'(k);
        if (k == count - 9'd1) begin
          state_next = slc8d_pkg::ST_CUT;
        end
      end
      slc8d_pkg::ST_CUT: begin
        // Cut the store through the frame end and rescan from the front
        cut_sum      = {1'b0, (slc8d_pkg::IW)'(rx_head)} + {1'b0, frame_end};
        rx_head_next = (cut_sum >= RX_DEPTH_W) ? slc8d_pkg::RX_AW'(cut_sum - RX_DEPTH_W)
                                               : slc8d_pkg::RX_AW'(cut_sum);
        rx_fill_next = slc8d_pkg::RX_CW'(fill_w - frame_end);
        idx_next     = '0;
        state_next   = slc8d_pkg::ST_FIND;
      end
      default: begin
        state_next = slc8d_pkg::ST_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= slc8d_pkg::ST_IDLE;
      rx_head   <= '0;
      rx_fill   <= '0;
      out_head  <= '0;
      out_fill  <= '0;
      rx_ovf    <= 1'b0;
      out_ovf   <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      rx_head   <= rx_head_next;
      rx_fill   <= rx_fill_next;
      out_head  <= out_head_next;
      out_fill  <= out_fill_next;
      rx_ovf    <= rx_ovf_next;
      out_ovf   <= out_ovf_next;
      m_tvalid  <= m_valid_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte <= slc8d_pkg::SYNC_RESET;
      crc_poly  <= slc8d_pkg::POLY_RESET;
      crc_init  <= slc8d_pkg::INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        slc8d_pkg::REG_SYNC_BYTE: sync_byte <= cfg_wdata;
        slc8d_pkg::REG_CRC_POLY:  crc_poly  <= cfg_wdata;
        slc8d_pkg::REG_CRC_INIT:  crc_init  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    len_r   <= len_next;
    type_r  <= type_next;
    crc     <= crc_next;
    k       <= k_next;
    bitc    <= bitc_next;
    m_tdata <= m_data_next;
    m_tuser <= m_user_next;
    m_tlast <= m_last_next;
  end

  // Byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= s_tdata;
    end
    rx_rd <= rx_mem[rx_raddr];
  end

  // Output queue: one write port, registered read at the head
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    q_rd <= q_mem[out_head];
  end

  // Checks
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (!m_tvalid || m_tready))
    else $error("input taken while output beat would be lost");
  a_rx_fill: assert property (@(posedge clk) disable iff (rst)
    rx_fill <= slc8d_pkg::RX_CW'(slc8d_pkg::RX_DEPTH))
    else $error("byte store overfilled");
  a_q_fill: assert property (@(posedge clk) disable iff (rst)
    out_fill <= slc8d_pkg::QCW'(slc8d_pkg::OUT_DEPTH))
    else $error("output queue overfilled");
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[15:0] == 16'd0 && !m_tlast && m_tuser[2:1] == 2'd0))
    else $error("empty pop carries data");

endmodule
